### src/sine_easing_curve_assert.svh
// Assertion macros used by the checker file of the sine easing curve.
`ifndef SINE_EASING_CURVE_ASSERT_SVH
`define SINE_EASING_CURVE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sine easing check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sine easing check failed");

`endif

### src/sec_pkg.sv
package sec_pkg;

    localparam int DEF_TIME_BITS = 24;
    localparam int DEF_FRAC_BITS = 16;

    localparam int CFG_INDEX_BITS = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE_MODE  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_TICKS = CFG_INDEX_BITS'(1);

    // Curve modes. The unused code acts as in-out.
    localparam logic [1:0] MODE_IN     = 2'd0;
    localparam logic [1:0] MODE_OUT    = 2'd1;
    localparam logic [1:0] MODE_IN_OUT = 2'd2;

    localparam int Q30_SHIFT  = 30;
    localparam int POLY_STEPS = 8;

    localparam logic signed [63:0] Q30_HALF = 64'sd536870912;

    // Odd Taylor-like coefficients of the quarter-wave sine in Q30, x^13 first.
    localparam logic signed [31:0] SINE_COEF [POLY_STEPS-1] = '{
        32'sd61,
        -32'sd3864,
        32'sd172272,
        -32'sd5026995,
        32'sd85569306,
        -32'sd693598668,
        32'sd1686629713
    };

    typedef struct packed {
        logic valid;
        logic clamp;
    } stage_ctl_t;

    // Rounds a Q60 product to Q30, ties away from zero, and adds a Q30 coefficient.
    // For a negative product, subtracting one from the bias turns the floor of the
    // arithmetic shift into the mirrored rounding of the magnitude.
    function automatic logic signed [31:0] q30_round_add(
        input logic signed [63:0] prod,
        input logic signed [31:0] coef
    );
        logic signed [63:0] coef_w;
        logic signed [63:0] bias;
        logic signed [63:0] sum;
        logic signed [63:0] shifted;
        coef_w  = coef;
        bias    = prod[63] ? (Q30_HALF - 64'sd1) : Q30_HALF;
        sum     = prod + bias + (coef_w <<< Q30_SHIFT);
        shifted = sum >>> Q30_SHIFT;
        return shifted[31:0];
    endfunction

endpackage

### src/sine_easing_curve.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     elapsed_ticks
// out       output     out_valid / out_stall   eased_value, clamped
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item enters per cycle while in_stall is low. Between the input and output
// registers lie the restoring divider, one quotient bit per stage, and the eight
// multiply and round stage pairs of the sine polynomial.
// Reset clears all valid bits, curve_mode to sine in and total_ticks to one.
// A skid register behind the output register takes the last item when out_stall
// holds; in_stall is that register's full flag, so the pipeline freezes as a whole.
module sine_easing_curve #(
    parameter int TIME_BITS = sec_pkg::DEF_TIME_BITS,
    parameter int FRAC_BITS = sec_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [TIME_BITS-1:0]              elapsed_ticks,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [FRAC_BITS:0]                eased_value,
    output logic                              clamped,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sec_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]              cfg_data
);

    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int SQ_W       = 2 * Q_W;
    localparam int X_SHIFT    = sec_pkg::Q30_SHIFT - FRAC_BITS;
    localparam int LAST       = sec_pkg::POLY_STEPS - 1;

    localparam logic [Q_W-1:0]  ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [30:0]     Q30_ONE = 31'h4000_0000;
    localparam logic [30:0]     R_RND   = 31'(1) << (X_SHIFT - 1);
    localparam logic [SQ_W-1:0] SQ_RND  = SQ_W'(1) << (FRAC_BITS - 1);

    // Configuration registers.
    logic [1:0]           curve_mode_reg;
    logic [TIME_BITS-1:0] total_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg  <= sec_pkg::MODE_IN;
            total_ticks_reg <= TIME_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sec_pkg::REG_CURVE_MODE:  curve_mode_reg  <= cfg_data[1:0];
                sec_pkg::REG_TOTAL_TICKS: total_ticks_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // The whole pipeline moves while the skid register is empty.
    logic adv;
    logic skid_valid_reg;

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Input stage.
    sec_pkg::stage_ctl_t  a_ctl_reg, a_ctl_next;
    logic [TIME_BITS-1:0] a_elapsed_reg;

    always_comb
    begin
        a_ctl_next.valid = in_valid;
        a_ctl_next.clamp = (total_ticks_reg == '0) || (elapsed_ticks > total_ticks_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_ctl_reg <= '0;
        else if (adv)
            a_ctl_reg <= a_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            a_elapsed_reg <= elapsed_ticks;
    end

    // Restoring divider: one quotient bit per stage. The remainder stays below
    // the duration, so the doubled remainder fits one extra bit.
    sec_pkg::stage_ctl_t  d_ctl_reg [DIV_STAGES];
    logic [TIME_BITS-1:0] d_rem_reg [DIV_STAGES];
    logic [Q_W-1:0]       d_quo_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        sec_pkg::stage_ctl_t  ctl_in;
        logic [TIME_BITS:0]   rem_in;
        logic [Q_W-1:0]       quo_in;
        logic                 ge;
        logic [TIME_BITS:0]   rem_diff;
        logic [TIME_BITS-1:0] rem_next;
        logic [Q_W-1:0]       quo_next;

        if (k == 0)
        begin : g_first
            assign ctl_in = a_ctl_reg;
            assign rem_in = {1'b0, a_elapsed_reg};
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign ctl_in = d_ctl_reg[k-1];
            assign rem_in = {d_rem_reg[k-1], 1'b0};
            assign quo_in = d_quo_reg[k-1];
        end

        assign ge       = rem_in >= {1'b0, total_ticks_reg};
        assign rem_diff = rem_in - {1'b0, total_ticks_reg};
        assign rem_next = ge ? rem_diff[TIME_BITS-1:0] : rem_in[TIME_BITS-1:0];
        assign quo_next = {quo_in[Q_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_ctl_reg[k] <= '0;
            else if (adv)
                d_ctl_reg[k] <= ctl_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_rem_reg[k] <= rem_next;
                d_quo_reg[k] <= quo_next;
            end
        end
    end

    // Argument stage: saturate, mirror for sine in, scale to Q30.
    sec_pkg::stage_ctl_t x_ctl_reg;
    logic signed [31:0]  x_reg, x_next;
    logic [Q_W-1:0]      t_sel;
    logic [Q_W-1:0]      p_arg;

    always_comb
    begin
        t_sel = d_ctl_reg[DIV_STAGES-1].clamp ? ONE_Q : d_quo_reg[DIV_STAGES-1];
        case (curve_mode_reg)
            sec_pkg::MODE_IN: p_arg = ONE_Q - t_sel;
            default:          p_arg = t_sel;
        endcase
        x_next = 32'(p_arg) << X_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x_ctl_reg <= '0;
        else if (adv)
            x_ctl_reg <= d_ctl_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            x_reg <= x_next;
    end

    // Polynomial: step 0 squares x, steps 1..6 run Horner over x^2,
    // the last step multiplies by x. Each step is a multiply stage and a
    // round-and-add stage.
    sec_pkg::stage_ctl_t pm_ctl_reg  [sec_pkg::POLY_STEPS];
    logic signed [63:0]  pm_prod_reg [sec_pkg::POLY_STEPS];
    logic signed [31:0]  pm_x_reg    [sec_pkg::POLY_STEPS];
    logic signed [31:0]  pm_y_reg    [sec_pkg::POLY_STEPS];
    sec_pkg::stage_ctl_t pr_ctl_reg  [sec_pkg::POLY_STEPS];
    logic signed [31:0]  pr_acc_reg  [sec_pkg::POLY_STEPS];
    logic signed [31:0]  pr_x_reg    [sec_pkg::POLY_STEPS];
    logic signed [31:0]  pr_y_reg    [sec_pkg::POLY_STEPS];

    for (genvar j = 0; j < sec_pkg::POLY_STEPS; j++)
    begin : g_poly
        sec_pkg::stage_ctl_t ctl_in;
        logic signed [31:0]  mul_a;
        logic signed [31:0]  mul_b;
        logic signed [31:0]  x_in;
        logic signed [31:0]  y_in;
        logic signed [63:0]  mul_a_w;
        logic signed [63:0]  mul_b_w;
        logic signed [63:0]  prod_next;
        logic signed [31:0]  acc_next;
        logic signed [31:0]  y_next;

        if (j == 0)
        begin : g_sq_in
            // The square is not formed yet; the carried y is replaced below.
            assign ctl_in = x_ctl_reg;
            assign mul_a  = x_reg;
            assign mul_b  = x_reg;
            assign x_in   = x_reg;
            assign y_in   = x_reg;
        end
        else if (j == LAST)
        begin : g_fin_in
            assign ctl_in = pr_ctl_reg[j-1];
            assign mul_a  = pr_acc_reg[j-1];
            assign mul_b  = pr_x_reg[j-1];
            assign x_in   = pr_x_reg[j-1];
            assign y_in   = pr_y_reg[j-1];
        end
        else
        begin : g_hor_in
            assign ctl_in = pr_ctl_reg[j-1];
            assign mul_a  = pr_acc_reg[j-1];
            assign mul_b  = pr_y_reg[j-1];
            assign x_in   = pr_x_reg[j-1];
            assign y_in   = pr_y_reg[j-1];
        end

        assign mul_a_w   = mul_a;
        assign mul_b_w   = mul_b;
        assign prod_next = mul_a_w * mul_b_w;

        if (j == 0)
        begin : g_sq_out
            assign acc_next = sec_pkg::SINE_COEF[0];
            assign y_next   = sec_pkg::q30_round_add(pm_prod_reg[j], 32'sd0);
        end
        else if (j == LAST)
        begin : g_fin_out
            assign acc_next = sec_pkg::q30_round_add(pm_prod_reg[j], 32'sd0);
            assign y_next   = pm_y_reg[j];
        end
        else
        begin : g_hor_out
            assign acc_next = sec_pkg::q30_round_add(pm_prod_reg[j], sec_pkg::SINE_COEF[j]);
            assign y_next   = pm_y_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pm_ctl_reg[j] <= '0;
                pr_ctl_reg[j] <= '0;
            end
            else if (adv)
            begin
                pm_ctl_reg[j] <= ctl_in;
                pr_ctl_reg[j] <= pm_ctl_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pm_prod_reg[j] <= prod_next;
                pm_x_reg[j]    <= x_in;
                pm_y_reg[j]    <= y_in;
                pr_acc_reg[j]  <= acc_next;
                pr_x_reg[j]    <= pm_x_reg[j];
                pr_y_reg[j]    <= y_next;
            end
        end
    end

    // Clamp the Q30 sine to [0, 1] and round to the output precision.
    sec_pkg::stage_ctl_t s_ctl_reg;
    logic [Q_W-1:0]      s_val_reg, s_val_next;
    logic signed [31:0]  r_q30;
    logic [30:0]         r_clip;
    logic [30:0]         r_sum;

    always_comb
    begin
        r_q30 = pr_acc_reg[LAST];
        if (r_q30[31])
            r_clip = '0;
        else if (r_q30[30:0] > Q30_ONE)
            r_clip = Q30_ONE;
        else
            r_clip = r_q30[30:0];
        r_sum      = r_clip + R_RND;
        s_val_next = Q_W'(r_sum >> X_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_ctl_reg <= '0;
        else if (adv)
            s_ctl_reg <= pr_ctl_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s_val_reg <= s_val_next;
    end

    // Square for in-out.
    sec_pkg::stage_ctl_t q_ctl_reg;
    logic [Q_W-1:0]      q_s_reg;
    logic [SQ_W-1:0]     q_sq_reg, q_sq_next;

    assign q_sq_next = SQ_W'(s_val_reg) * SQ_W'(s_val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_ctl_reg <= '0;
        else if (adv)
            q_ctl_reg <= s_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_s_reg  <= s_val_reg;
            q_sq_reg <= q_sq_next;
        end
    end

    // Mode select feeding the output register.
    logic [Q_W-1:0]  last_value;
    logic [SQ_W-1:0] sq_sum;

    always_comb
    begin
        sq_sum = q_sq_reg + SQ_RND;
        case (curve_mode_reg)
            sec_pkg::MODE_IN:  last_value = ONE_Q - q_s_reg;
            sec_pkg::MODE_OUT: last_value = q_s_reg;
            default:           last_value = sq_sum[FRAC_BITS +: Q_W];
        endcase
    end

    // Output register with skid register.
    logic           out_valid_reg, out_valid_next;
    logic [Q_W-1:0] out_value_reg;
    logic           out_clamp_reg;
    logic           skid_valid_next;
    logic [Q_W-1:0] skid_value_reg;
    logic           skid_clamp_reg;
    logic           out_free;
    logic           out_load;
    logic           out_from_skid;
    logic           skid_load;

    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        out_from_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_load        = 1'b1;
                out_from_skid   = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (q_ctl_reg.valid)
        begin
            if (out_free)
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= out_from_skid ? skid_value_reg : last_value;
            out_clamp_reg <= out_from_skid ? skid_clamp_reg : q_ctl_reg.clamp;
        end
        if (skid_load)
        begin
            skid_value_reg <= last_value;
            skid_clamp_reg <= q_ctl_reg.clamp;
        end
    end

    assign out_valid   = out_valid_reg;
    assign eased_value = out_value_reg;
    assign clamped     = out_clamp_reg;

endmodule

### src/sec_checker.sv
`include "sine_easing_curve_assert.svh"

module sec_checker #(
    parameter int FRAC_BITS = sec_pkg::DEF_FRAC_BITS
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [FRAC_BITS:0] eased_value,
    input logic               clamped
);

    localparam logic [FRAC_BITS:0] ONE_VAL = {1'b1, {FRAC_BITS{1'b0}}};

    // A held result keeps its payload.
    `SEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(eased_value) && $stable(clamped))

    // A saturated or zero-duration item always eases to exactly one.
    `SEC_ASSERT_NOW(a_clamp_one, clk, rst_n, out_valid && clamped, eased_value == ONE_VAL)

    // The input only stalls after the output was held back.
    `SEC_ASSERT_NOW(a_stall_cause, clk, rst_n, $rose(in_stall), $past(out_valid && out_stall))

    // Once the output is free, the parked item moves on and the input opens.
    `SEC_ASSERT_NEXT(a_stall_drain, clk, rst_n, in_stall && !out_stall, !in_stall)

endmodule

bind sine_easing_curve sec_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_sec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .eased_value(eased_value),
    .clamped    (clamped)
);
